[sv/hbd_pkg.sv]
// Shared types and constants of the home computer bus decoder.
package hbd_pkg;

  // Target store codes.
  localparam logic [2:0] TGT_NONE     = 3'd0;
  localparam logic [2:0] TGT_RAM      = 3'd1;
  localparam logic [2:0] TGT_CART     = 3'd2;
  localparam logic [2:0] TGT_MON      = 3'd3;
  localparam logic [2:0] TGT_CTRL     = 3'd4;
  localparam logic [2:0] TGT_UNMAPPED = 3'd5;

  // Cartridge kinds.
  localparam logic [1:0] CART_SIMPLE = 2'd0;
  localparam logic [1:0] CART_BANKED = 2'd1;
  localparam logic [1:0] CART_EXT_OS = 2'd2;

  // Named register addresses in the I/O page.
  localparam logic [15:0] ADDR_PORT0     = 16'hA7C0;
  localparam logic [15:0] ADDR_PORT1     = 16'hA7C1;
  localparam logic [15:0] ADDR_PORT2     = 16'hA7C2;
  localparam logic [15:0] ADDR_PORT3     = 16'hA7C3;
  localparam logic [15:0] ADDR_CART      = 16'hA7CB;
  localparam logic [15:0] ADDR_JOY_POS   = 16'hA7CC;
  localparam logic [15:0] ADDR_JOY_ACT   = 16'hA7CD;
  localparam logic [15:0] ADDR_JOY_DIR_A = 16'hA7CE;
  localparam logic [15:0] ADDR_JOY_DIR_B = 16'hA7CF;
  localparam logic [15:0] ADDR_VSYNC_INV = 16'hA7D8;
  localparam logic [15:0] ADDR_ALL_ONES  = 16'hA7E1;
  localparam logic [15:0] ADDR_HSYNC     = 16'hA7E6;
  localparam logic [15:0] ADDR_VSYNC     = 16'hA7E7;
  localparam logic [15:0] ADDR_IO_END    = 16'hA800;
  localparam logic [15:0] ADDR_CART_BASE = 16'hB000;
  localparam logic [15:0] BANK_SEL_MASK  = 16'hFFFC;
  localparam logic [15:0] BANK_SEL_ADDR  = 16'hBFFC;

  // Address pages.
  localparam logic [3:0] PAGE_VIDEO_END = 4'h1;
  localparam logic [3:0] PAGE_RAM_END   = 4'h9;
  localparam logic [3:0] PAGE_IO        = 4'hA;
  localparam logic [3:0] PAGE_CART      = 4'hB;
  localparam logic [3:0] PAGE_ROM_END   = 4'hE;

  // Write masks and fixed read values.
  localparam logic [7:0] MASK_PORT0   = 8'h5F;
  localparam logic [7:0] MASK_PORT1   = 8'h7F;
  localparam logic [7:0] MASK_PORT23  = 8'h3F;
  localparam logic [7:0] JOY_DIR_READ = 8'h04;
  localparam logic [16:0] RAM_OFFSET  = 17'h02000;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [8:0]  beam_line;
    logic [5:0]  beam_cycle;
    logic [63:0] key_released;
    logic [7:0]  joy_position;
    logic [7:0]  joy_action;
    logic        pen_button;
  } req_t;

  typedef struct packed {
    logic [7:0][7:0] io_ports;
    logic [7:0]      cart_flags;
    logic [5:0]      speaker_level;
  } state_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [2:0]  target;
    logic [16:0] phys_addr;
    logic [3:0]  border_color;
    logic [5:0]  sound_level;
  } rsp_t;

endpackage

[sv/hbd_decode.sv]
// Address decode, register read mux and next-state logic for one bus request.
module hbd_decode import hbd_pkg::*; (
  input  req_t       req,
  input  state_t     st,
  input  logic [1:0] cart_kind,
  output rsp_t       rsp,
  output state_t     st_next
);

  logic [3:0]  page;
  logic        frame_on;
  logic [7:0]  tn;
  logic [7:0]  hsync_byte;
  logic        bank_sw;
  logic [7:0]  flags_cur;
  logic [15:0] cart_off;
  logic [16:0] cart_phys;
  logic [16:0] mon_phys;
  logic [5:0]  port_num;
  logic [7:0]  rdata;
  logic [2:0]  target;
  logic [16:0] phys;

  assign page = req.addr[15:12];

  // Frame sync is high inside the visible window of lines 56 to 255.
  assign frame_on = !((req.beam_line < 9'd56) || (req.beam_line > 9'd255) ||
                      (req.beam_line == 9'd56 && req.beam_cycle < 6'd24) ||
                      (req.beam_line == 9'd255 && req.beam_cycle > 6'd62));
  assign tn = {frame_on, 7'b0};
  assign hsync_byte = (req.beam_cycle < 6'd23) ? 8'h00 : 8'h40;

  // On a banked cartridge, a read of the last four bytes of the window selects the bank.
  assign bank_sw = !req.op && page == PAGE_CART && cart_kind == CART_BANKED &&
                   (req.addr & BANK_SEL_MASK) == BANK_SEL_ADDR;
  assign flags_cur = bank_sw ? {st.cart_flags[7:2], req.addr[1:0]} : st.cart_flags;

  assign cart_off  = req.addr - ADDR_CART_BASE;
  assign cart_phys = {cart_kind == CART_EXT_OS && flags_cur[4], flags_cur[1:0],
                      cart_off[13:0]};
  assign mon_phys  = {3'b0, req.addr[13:0]};
  assign port_num  = req.addr[5:0];

  always_comb begin
    st_next = st;
    rdata   = 8'h00;
    target  = TGT_NONE;
    phys    = 17'h0;
    if (!req.op) begin
      if (page <= PAGE_VIDEO_END) begin
        target = TGT_RAM;
        phys   = {1'b0, req.addr} + {3'b0, st.io_ports[0][0], 13'b0};
      end else if (page <= PAGE_RAM_END) begin
        target = TGT_RAM;
        phys   = {1'b0, req.addr} + RAM_OFFSET;
      end else if (page == PAGE_IO) begin
        case (req.addr)
          ADDR_PORT0: rdata = st.io_ports[0] | 8'h80 | {2'b0, req.pen_button, 5'b0};
          ADDR_PORT1: rdata = st.io_ports[1] |
                              {req.key_released[st.io_ports[1][6:1]], 7'b0};
          ADDR_PORT2: rdata = st.io_ports[2];
          ADDR_PORT3: rdata = st.io_ports[3] | ~tn;
          ADDR_CART: rdata = {st.cart_flags[6], st.cart_flags[7], st.cart_flags[5:0]};
          ADDR_JOY_POS: rdata = st.io_ports[6][2] ? req.joy_position : st.io_ports[4];
          ADDR_JOY_ACT: rdata = st.io_ports[7][2] ?
                                (req.joy_action | {2'b0, st.speaker_level}) :
                                st.io_ports[5];
          ADDR_JOY_DIR_A: rdata = JOY_DIR_READ;
          ADDR_VSYNC_INV: rdata = ~tn;
          ADDR_ALL_ONES:  rdata = 8'hFF;
          ADDR_HSYNC:     rdata = hsync_byte;
          ADDR_VSYNC:     rdata = tn;
          default: begin
            if (req.addr < ADDR_PORT0) begin
              target = TGT_CTRL;
              phys   = {6'b0, req.addr[10:0]};
            end else if (req.addr < ADDR_IO_END) begin
              // Unnamed slots fall back to the kept ports 0-3 and 0x0c-0x0f.
              if (port_num[5:2] == 4'h0) begin
                rdata = st.io_ports[{1'b0, port_num[1:0]}];
              end else if (port_num[5:2] == 4'h3) begin
                rdata = st.io_ports[{1'b1, port_num[1:0]}];
              end
            end
          end
        endcase
      end else if (page <= PAGE_ROM_END) begin
        st_next.cart_flags = flags_cur;
        if (flags_cur[2]) begin
          target = TGT_CART;
          phys   = cart_phys;
        end else if (page == PAGE_CART) begin
          target = TGT_UNMAPPED;
        end else begin
          target = TGT_MON;
          phys   = mon_phys;
        end
      end else begin
        target = TGT_MON;
        phys   = mon_phys;
      end
    end else begin
      if (page <= PAGE_VIDEO_END) begin
        target = TGT_RAM;
        phys   = {1'b0, req.addr} + {3'b0, st.io_ports[0][0], 13'b0};
      end else if (page <= PAGE_RAM_END) begin
        target = TGT_RAM;
        phys   = {1'b0, req.addr} + RAM_OFFSET;
      end else if (page == PAGE_IO) begin
        case (req.addr)
          ADDR_PORT0: st_next.io_ports[0] = req.wdata & MASK_PORT0;
          ADDR_PORT1: begin
            st_next.io_ports[1]   = req.wdata & MASK_PORT1;
            st_next.speaker_level = {req.wdata[0], 5'b0};
          end
          ADDR_PORT2: st_next.io_ports[2] = req.wdata & MASK_PORT23;
          ADDR_PORT3: st_next.io_ports[3] = req.wdata & MASK_PORT23;
          ADDR_CART:  st_next.cart_flags  = req.wdata;
          ADDR_JOY_POS: st_next.io_ports[4] = req.wdata;
          ADDR_JOY_ACT: begin
            st_next.io_ports[5]   = req.wdata;
            st_next.speaker_level = req.wdata[5:0];
          end
          ADDR_JOY_DIR_A: st_next.io_ports[6] = req.wdata;
          ADDR_JOY_DIR_B: st_next.io_ports[7] = req.wdata;
          default: ;
        endcase
      end else if (page <= PAGE_ROM_END) begin
        // Only a write-enabled simple cartridge sees writes; the monitor ROM never does.
        if (st.cart_flags[3] && cart_kind == CART_SIMPLE) begin
          if (st.cart_flags[2]) begin
            target = TGT_CART;
            phys   = cart_phys;
          end else begin
            target = TGT_UNMAPPED;
          end
        end
      end
    end
  end

  assign rsp.rdata        = (target == TGT_NONE && !req.op) ? rdata : 8'h00;
  assign rsp.target       = target;
  assign rsp.phys_addr    = phys;
  assign rsp.border_color = st_next.io_ports[0][4:1];
  assign rsp.sound_level  = st_next.speaker_level;

endmodule

[sv/home_computer_bus_decoder.sv]
// Bus decoder of a small home computer: input register, decode, result register.
//
// One request on the in channel is one CPU bus access (op, addr, wdata) with the
// beam position, key, joystick and pen inputs sampled for it. Each request gives
// exactly one result on the out channel: the read byte for register reads, or the
// target store and physical address, plus the current border color and sound level.
// The cfg channel writes cart_kind; it is always ready; users must write it while idle.
// A request accepted at one clock edge is registered, decoded against the port
// registers and cartridge flags, and its result is registered when the result
// register is free or being taken, which raises out_valid. The state update of a
// request lands in the same edge as its result, so the next request sees it at
// once and one request per cycle is sustained while out_ready stays high.
// When out_ready is low the result register holds; the input register still takes
// one more request, and in_ready then drops until the result is taken.
// Synchronous reset clears both valid flags, the port registers, the cartridge
// flags, the speaker level and cart_kind.
module home_computer_bus_decoder import hbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [15:0] addr,
  input  logic [7:0]  wdata,
  input  logic [8:0]  beam_line,
  input  logic [5:0]  beam_cycle,
  input  logic [63:0] key_released,
  input  logic [7:0]  joy_position,
  input  logic [7:0]  joy_action,
  input  logic        pen_button,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  rdata,
  output logic [2:0]  target,
  output logic [16:0] phys_addr,
  output logic [3:0]  border_color,
  output logic [5:0]  sound_level
);

  logic       s1_valid;
  req_t       s1_req;
  logic       s1_fire;
  state_t     st;
  state_t     st_next;
  logic [1:0] cart_kind;
  rsp_t       rsp;
  rsp_t       out_rsp;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_kind <= CART_SIMPLE;
    end else if (cfg_valid && cfg_ready) begin
      cart_kind <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req <= '{op: op, addr: addr, wdata: wdata, beam_line: beam_line,
                  beam_cycle: beam_cycle, key_released: key_released,
                  joy_position: joy_position, joy_action: joy_action,
                  pen_button: pen_button};
    end
  end

  hbd_decode u_decode (
    .req       (s1_req),
    .st        (st),
    .cart_kind (cart_kind),
    .rsp       (rsp),
    .st_next   (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      st        <= st_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_rsp <= rsp;
    end
  end

  assign rdata        = out_rsp.rdata;
  assign target       = out_rsp.target;
  assign phys_addr    = out_rsp.phys_addr;
  assign border_color = out_rsp.border_color;
  assign sound_level  = out_rsp.sound_level;

endmodule

[sv/hbd_checker.sv]
// Port-level checks of the bus decoder and their binding to the top level.
module hbd_checker import hbd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  rdata,
  input logic [2:0]  target,
  input logic [16:0] phys_addr,
  input logic [3:0]  border_color,
  input logic [5:0]  sound_level
);

  // A stalled result must stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rdata) && $stable(target) &&
                               $stable(phys_addr) && $stable(sound_level) &&
                               $stable(border_color))
    else $error("result changed while stalled");

  // A read byte is only reported when no store is selected.
  a_rdata_reg_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && target != TGT_NONE |-> rdata == 8'h00)
    else $error("read byte with a store target");

  // No address is given when nothing is mapped.
  a_phys_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && (target == TGT_NONE || target == TGT_UNMAPPED) |-> phys_addr == 17'h0)
    else $error("physical address without a store");

  // RAM and ROM addresses stay inside their 64K stores.
  a_phys_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (target == TGT_RAM || target == TGT_MON || target == TGT_CTRL)
      |-> phys_addr[16] == 1'b0)
    else $error("physical address out of range");

endmodule

bind home_computer_bus_decoder hbd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .rdata        (rdata),
  .target       (target),
  .phys_addr    (phys_addr),
  .border_color (border_color),
  .sound_level  (sound_level)
);

[tb/sv/home_computer_bus_decoder_tb.sv]
// Self-checking testbench of the home computer bus decoder with a bus access predictor.
module home_computer_bus_decoder_tb;
  import hbd_pkg::*;

  localparam logic       OP_READ     = 1'b0;
  localparam logic       OP_WRITE    = 1'b1;
  localparam logic [1:0] CART_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         RANDOM_PER_PHASE = 100;
  localparam int         SQUEEZE_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t drv_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] rdata;
  logic [2:0] target;
  logic [16:0] phys_addr;
  logic [3:0] border_color;
  logic [5:0] sound_level;

  // Predictor state, kept in step with the accepted requests.
  logic [7:0] port_regs [8] = '{default: 8'h00};
  logic [7:0] cart_reg = 8'h00;
  logic [5:0] spk_level = 6'd0;
  logic [1:0] kind_sel = CART_SIMPLE;

  req_t pending_q [$];
  rsp_t expected_q [$];

  int tx_wait = 0;
  int rx_wait = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit squeeze = 1'b0;
  bit squeeze_done = 1'b0;
  int cycles = 0;
  int errors = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_reg_reads = 0;
  int n_cart_hits = 0;
  int n_unmapped = 0;
  int n_cfg_writes = 0;

  home_computer_bus_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (drv_req.op),
    .addr         (drv_req.addr),
    .wdata        (drv_req.wdata),
    .beam_line    (drv_req.beam_line),
    .beam_cycle   (drv_req.beam_cycle),
    .key_released (drv_req.key_released),
    .joy_position (drv_req.joy_position),
    .joy_action   (drv_req.joy_action),
    .pen_button   (drv_req.pen_button),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rdata        (rdata),
    .target       (target),
    .phys_addr    (phys_addr),
    .border_color (border_color),
    .sound_level  (sound_level)
  );

  always #2 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [16:0] cart_window_addr(input logic [15:0] a);
    logic [16:0] p;
    p = {1'b0, a} - {1'b0, ADDR_CART_BASE} + {1'b0, cart_reg[1:0], 14'd0};
    if (kind_sel == CART_EXT_OS && cart_reg[4]) p = p + 17'h10000;
    return p;
  endfunction

  // Decodes one bus access against the predictor state and applies its side effects.
  function automatic rsp_t decode_access(input req_t q);
    rsp_t r;
    logic [3:0] pg;
    logic [7:0] rd;
    logic [7:0] vsync;
    logic [5:0] p;
    r = '0;
    rd = 8'h00;
    pg = q.addr[15:12];
    vsync = 8'h80;
    if (q.beam_line < 9'd56 || q.beam_line > 9'd255) vsync = 8'h00;
    else if (q.beam_line == 9'd56 && q.beam_cycle < 6'd24) vsync = 8'h00;
    else if (q.beam_line == 9'd255 && q.beam_cycle > 6'd62) vsync = 8'h00;

    if (pg <= PAGE_VIDEO_END) begin
      r.target = TGT_RAM;
      r.phys_addr = {1'b0, q.addr} + (port_regs[0][0] ? RAM_OFFSET : 17'd0);
    end else if (pg <= PAGE_RAM_END) begin
      r.target = TGT_RAM;
      r.phys_addr = {1'b0, q.addr} + RAM_OFFSET;
    end else if (q.op == OP_READ) begin
      if (pg == PAGE_IO) begin
        case (q.addr)
          ADDR_PORT0:     rd = port_regs[0] | 8'h80 | {2'b00, q.pen_button, 5'd0};
          ADDR_PORT1:     rd = port_regs[1] |
                               (q.key_released[port_regs[1][6:1]] ? 8'h80 : 8'h00);
          ADDR_PORT2:     rd = port_regs[2];
          ADDR_PORT3:     rd = port_regs[3] | ~vsync;
          ADDR_CART:      rd = {cart_reg[6], cart_reg[7], cart_reg[5:0]};
          ADDR_JOY_POS:   rd = port_regs[6][2] ? q.joy_position : port_regs[4];
          ADDR_JOY_ACT:   rd = port_regs[7][2] ? (q.joy_action | {2'b00, spk_level})
                                               : port_regs[5];
          ADDR_JOY_DIR_A: rd = JOY_DIR_READ;
          ADDR_VSYNC_INV: rd = ~vsync;
          ADDR_ALL_ONES:  rd = 8'hFF;
          ADDR_HSYNC:     rd = (q.beam_cycle < 6'd23) ? 8'h00 : 8'h40;
          ADDR_VSYNC:     rd = vsync;
          default: begin
            if (q.addr < ADDR_PORT0) begin
              r.target = TGT_CTRL;
              r.phys_addr = {6'd0, q.addr[10:0]};
            end else if (q.addr < ADDR_IO_END) begin
              p = q.addr[5:0];
              if (p <= 6'd3) rd = port_regs[p[2:0]];
              else if (p >= 6'd12 && p <= 6'd15) rd = port_regs[{1'b1, p[1:0]}];
            end
          end
        endcase
      end else if (pg <= PAGE_ROM_END) begin
        // Bank select happens on the read itself, before the window is decoded.
        if (pg == PAGE_CART && kind_sel == CART_BANKED &&
            (q.addr & BANK_SEL_MASK) == BANK_SEL_ADDR)
          cart_reg[1:0] = q.addr[1:0];
        if (cart_reg[2]) begin
          r.target = TGT_CART;
          r.phys_addr = cart_window_addr(q.addr);
        end else if (pg == PAGE_CART) begin
          r.target = TGT_UNMAPPED;
        end else begin
          r.target = TGT_MON;
          r.phys_addr = {1'b0, q.addr - 16'hC000};
        end
      end else begin
        r.target = TGT_MON;
        r.phys_addr = {1'b0, q.addr - 16'hC000};
      end
    end else begin
      if (pg == PAGE_IO) begin
        case (q.addr)
          ADDR_PORT0: port_regs[0] = q.wdata & MASK_PORT0;
          ADDR_PORT1: begin
            port_regs[1] = q.wdata & MASK_PORT1;
            spk_level = {q.wdata[0], 5'd0};
          end
          ADDR_PORT2:     port_regs[2] = q.wdata & MASK_PORT23;
          ADDR_PORT3:     port_regs[3] = q.wdata & MASK_PORT23;
          ADDR_CART:      cart_reg = q.wdata;
          ADDR_JOY_POS:   port_regs[4] = q.wdata;
          ADDR_JOY_ACT: begin
            port_regs[5] = q.wdata;
            spk_level = q.wdata[5:0];
          end
          ADDR_JOY_DIR_A: port_regs[6] = q.wdata;
          ADDR_JOY_DIR_B: port_regs[7] = q.wdata;
          default: ;
        endcase
      end else if (pg <= PAGE_ROM_END) begin
        if (cart_reg[3] && kind_sel == CART_SIMPLE) begin
          if (cart_reg[2]) begin
            r.target = TGT_CART;
            r.phys_addr = cart_window_addr(q.addr);
          end else begin
            r.target = TGT_UNMAPPED;
          end
        end
      end
    end

    r.rdata = (r.target == TGT_NONE && q.op == OP_READ) ? rd : 8'h00;
    r.border_color = port_regs[0][4:1];
    r.sound_level = spk_level;
    return r;
  endfunction

  function automatic req_t new_access(input logic o, input logic [15:0] a,
                                      input logic [7:0] d);
    req_t q;
    q.op = o;
    q.addr = a;
    q.wdata = d;
    case ($urandom_range(0, 7))
      0: q.beam_line = 9'd55;
      1: q.beam_line = 9'd56;
      2: q.beam_line = 9'd255;
      3: q.beam_line = 9'd256;
      default: q.beam_line = 9'($urandom_range(0, 511));
    endcase
    case ($urandom_range(0, 7))
      0: q.beam_cycle = 6'd22;
      1: q.beam_cycle = 6'd23;
      2: q.beam_cycle = 6'd24;
      3: q.beam_cycle = 6'd63;
      default: q.beam_cycle = 6'($urandom_range(0, 63));
    endcase
    q.key_released = {$urandom, $urandom};
    q.joy_position = 8'($urandom_range(0, 255));
    q.joy_action = 8'($urandom_range(0, 255));
    q.pen_button = 1'($urandom_range(0, 1));
    return q;
  endfunction

  function automatic req_t random_access();
    int r;
    logic [15:0] a;
    r = $urandom_range(0, 99);
    if (r < 12) a = 16'($urandom_range(16'h0000, 16'h1FFF));
    else if (r < 22) a = 16'($urandom_range(16'h2000, 16'h9FFF));
    else if (r < 24) a = 16'($urandom_range(16'hA000, 16'hA7BF));
    else if (r < 50) begin
      case ($urandom_range(0, 12))
        0: a = ADDR_PORT0;
        1: a = ADDR_PORT1;
        2: a = ADDR_PORT2;
        3: a = ADDR_PORT3;
        4: a = ADDR_CART;
        5: a = ADDR_JOY_POS;
        6: a = ADDR_JOY_ACT;
        7: a = ADDR_JOY_DIR_A;
        8: a = ADDR_JOY_DIR_B;
        9: a = ADDR_VSYNC_INV;
        10: a = ADDR_ALL_ONES;
        11: a = ADDR_HSYNC;
        default: a = ADDR_VSYNC;
      endcase
    end
    else if (r < 58) a = 16'($urandom_range(16'hA7C0, 16'hA7FF));
    else if (r < 60) a = 16'($urandom_range(16'hA800, 16'hAFFF));
    else if (r < 66) a = 16'($urandom_range(16'hBFFC, 16'hBFFF));
    else if (r < 88) a = 16'($urandom_range(16'hB000, 16'hEFFF));
    else a = 16'($urandom_range(16'hF000, 16'hFFFF));
    return new_access(1'($urandom_range(0, 1)), a, 8'($urandom_range(0, 255)));
  endfunction

  task automatic queue_access(input logic o, input logic [15:0] a, input logic [7:0] d);
    pending_q.push_back(new_access(o, a, d));
  endtask

  // Mostly single random requests, mixed with short sequences that set up state and use it.
  task automatic queue_random(input int count);
    int n;
    int pick;
    logic [7:0] flags;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pending_q.push_back(random_access());
        n = n + 1;
      end else if (pick < 80) begin
        flags = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) flags[2] = 1'b1;
        queue_access(OP_WRITE, ADDR_CART, flags);
        repeat (3) begin
          if ($urandom_range(0, 3) == 0)
            queue_access(1'($urandom_range(0, 1)),
                         16'($urandom_range(16'hBFFC, 16'hBFFF)),
                         8'($urandom_range(0, 255)));
          else
            queue_access(1'($urandom_range(0, 1)),
                         16'($urandom_range(16'hB000, 16'hEFFF)),
                         8'($urandom_range(0, 255)));
        end
        n = n + 4;
      end else if (pick < 88) begin
        queue_access(OP_WRITE, ADDR_PORT1, 8'($urandom_range(0, 255)));
        queue_access(OP_READ, ADDR_PORT1, 8'($urandom_range(0, 255)));
        n = n + 2;
      end else if (pick < 95) begin
        queue_access(OP_WRITE, $urandom_range(0, 1) ? ADDR_JOY_DIR_A : ADDR_JOY_DIR_B,
                     8'($urandom_range(0, 255)));
        queue_access(OP_READ, $urandom_range(0, 1) ? ADDR_JOY_POS : ADDR_JOY_ACT,
                     8'($urandom_range(0, 255)));
        n = n + 2;
      end else begin
        queue_access(OP_WRITE, ADDR_PORT0, 8'($urandom_range(0, 255)));
        queue_access(OP_READ, 16'($urandom_range(16'h0000, 16'h1FFF)),
                     8'($urandom_range(0, 255)));
        n = n + 2;
      end
    end
  endtask

  // Sampled on the falling edge so that the driver's updates of the rising edge have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cart_kind(input logic [1:0] k);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    kind_sel = k;
    n_cfg_writes = n_cfg_writes + 1;
  endtask

  // Request driver: predicts each accepted request and offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_t e;
        e = decode_access(drv_req);
        expected_q.push_back(e);
        if (drv_req.op == OP_READ) n_reads = n_reads + 1;
        else n_writes = n_writes + 1;
        if (drv_req.op == OP_READ && e.target == TGT_NONE) n_reg_reads = n_reg_reads + 1;
        if (e.target == TGT_CART) n_cart_hits = n_cart_hits + 1;
        if (e.target == TGT_UNMAPPED) n_unmapped = n_unmapped + 1;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait != 0) begin
          tx_wait <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          drv_req <= pending_q.pop_front();
          in_valid <= 1'b1;
          tx_wait <= tx_gaps_on ? gap_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver back-pressure, including one long hold while requests keep coming.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (squeeze && !squeeze_done) begin
      squeeze_done <= 1'b1;
      rx_wait <= SQUEEZE_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
      rx_wait <= gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string what, input logic [16:0] want,
                                      input logic [16:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      errors = errors + 1;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      rsp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request outstanding, actual rdata 0x%0h target %0d",
                 $time, rdata, target);
        errors = errors + 1;
      end else begin
        e = expected_q.pop_front();
        check_field("rdata", 17'(e.rdata), 17'(rdata));
        check_field("target", 17'(e.target), 17'(target));
        check_field("phys_addr", e.phys_addr, phys_addr);
        check_field("border_color", 17'(e.border_color), 17'(border_color));
        check_field("sound_level", 17'(e.sound_level), 17'(sound_level));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    req_t q;
    logic [1:0] k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_cart_kind(CART_SIMPLE);

    // Directed pass over the memory map, the named ports and the cartridge corner cases.
    queue_access(OP_READ, 16'h0000, 8'h00);
    queue_access(OP_WRITE, ADDR_PORT0, 8'hFF);
    queue_access(OP_READ, 16'h1FFF, 8'h00);
    queue_access(OP_WRITE, 16'h2000, 8'hFF);
    queue_access(OP_READ, 16'h9FFF, 8'h00);
    queue_access(OP_READ, 16'hA000, 8'h00);
    queue_access(OP_READ, 16'hA7BF, 8'h00);
    q = new_access(OP_READ, ADDR_PORT0, 8'h00);
    q.pen_button = 1'b1;
    pending_q.push_back(q);
    queue_access(OP_WRITE, ADDR_PORT1, 8'hFF);
    queue_access(OP_READ, ADDR_PORT1, 8'h00);
    queue_access(OP_WRITE, ADDR_PORT3, 8'hFF);
    q = new_access(OP_READ, ADDR_PORT3, 8'h00);
    q.beam_line = 9'd56;
    q.beam_cycle = 6'd23;
    pending_q.push_back(q);
    q = new_access(OP_READ, ADDR_VSYNC, 8'h00);
    q.beam_line = 9'd255;
    q.beam_cycle = 6'd63;
    pending_q.push_back(q);
    queue_access(OP_WRITE, ADDR_JOY_ACT, 8'hFF);
    queue_access(OP_WRITE, ADDR_JOY_DIR_A, JOY_DIR_READ);
    queue_access(OP_WRITE, ADDR_JOY_DIR_B, JOY_DIR_READ);
    queue_access(OP_READ, ADDR_JOY_POS, 8'h00);
    queue_access(OP_READ, ADDR_JOY_ACT, 8'h00);
    queue_access(OP_READ, ADDR_JOY_DIR_B, 8'h00);
    queue_access(OP_READ, 16'hA7F0, 8'h00);
    queue_access(OP_WRITE, 16'hA7D0, 8'h55);
    queue_access(OP_READ, ADDR_IO_END, 8'h00);
    queue_access(OP_READ, ADDR_CART_BASE, 8'h00);
    queue_access(OP_WRITE, ADDR_CART, 8'h08);
    queue_access(OP_WRITE, 16'hC000, 8'h12);
    queue_access(OP_WRITE, ADDR_CART, 8'h1F);
    queue_access(OP_READ, 16'hBFFF, 8'h00);
    queue_access(OP_WRITE, 16'hEFFF, 8'h34);
    queue_access(OP_READ, ADDR_CART, 8'h00);
    queue_access(OP_READ, 16'hFFFF, 8'h00);
    queue_access(OP_WRITE, 16'hF000, 8'h56);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0, 4: k = CART_SIMPLE;
        1, 6: k = CART_BANKED;
        2, 5: k = CART_EXT_OS;
        default: k = CART_UNUSED;
      endcase
      write_cart_kind(k);
      tx_gaps_on = (ph != 1 && ph != 4);
      rx_gaps_on = (ph != 4);
      if (k == CART_BANKED) begin
        queue_access(OP_WRITE, ADDR_CART, 8'h04);
        queue_access(OP_READ, BANK_SEL_ADDR + 16'd2, 8'h00);
        queue_access(OP_READ, ADDR_CART_BASE + 16'h0123, 8'h00);
      end else if (k == CART_EXT_OS) begin
        queue_access(OP_WRITE, ADDR_CART, 8'h1F);
        queue_access(OP_READ, 16'hC000, 8'h00);
        queue_access(OP_WRITE, 16'hC000, 8'h00);
      end
      queue_random(RANDOM_PER_PHASE);
      // Hold the result side off while the sender streams, so the input stalls.
      if (ph == 1) squeeze = 1'b1;
      wait_idle();
    end

    $display("Checked %0d reads and %0d writes over %0d cartridge kind settings,",
             n_reads, n_writes, n_cfg_writes);
    $display("including %0d register reads, %0d cartridge hits and %0d unmapped accesses.",
             n_reg_reads, n_cart_hits, n_unmapped);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
